>>> rtl/wcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcs_pkg: shared types and constants of the chamfer score block
// Item carried from the front end to the accumulator, register indexes and
// fixed sizes.
// ----------------------------------------------------------------------------
package wcs_pkg;

	// default number of entries of the gaussian table
	localparam int unsigned WCS_EXP_TABLE_DEPTH = 1024;

	// weights at or below this are treated as noise, q0.16
	localparam logic [15:0] WCS_NOISE_FLOOR = 16'd6;

	// exponent span [0,16) in q24.24 occupies the low 28 bits
	localparam int unsigned WCS_EXP_SPAN_BITS = 28;

	// entries of the queue between front end and accumulator
	localparam int unsigned WCS_QUEUE_DEPTH = 4;

	// configuration register indexes
	localparam logic WCS_REG_INV_SIGMA_SQ = 1'b0;
	localparam logic WCS_REG_MIN_WEIGHT   = 1'b1;

	// one classified pixel: weight times gaussian, and the weight it adds
	typedef struct packed {
		logic [31:0] product;
		logic [15:0] weight;
		logic        last;
	} wcs_item_t;

endpackage

>>> rtl/wcs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcs_front: pixel intake and gaussian lookup pipeline
// Squares the distance, scales by 1/sigma^2, looks up the gaussian table and
// forms weight times gaussian; noise pixels leave with zero contribution.
// ----------------------------------------------------------------------------
module wcs_front #(
	parameter int unsigned EXP_TABLE_DEPTH = wcs_pkg::WCS_EXP_TABLE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [15:0]       rail_weight,
	input  logic [15:0]       distance_m,
	input  logic              last_pixel,
	input  logic [15:0]       inv_sigma_sq,
	output wcs_pkg::wcs_item_t item,
	output logic              item_valid,
	input  logic              item_ready
);
	import wcs_pkg::*;

	localparam int unsigned IW = $clog2(EXP_TABLE_DEPTH);
	localparam int unsigned SW = WCS_EXP_SPAN_BITS + IW;
	localparam logic [63:0] Q40_ONE = 64'd1 << 40;

	// table build, elaboration only

	function automatic logic [63:0] mul_q40(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] ah, al, bh, bl, mid;
		ah  = a >> 20;
		al  = a & 64'hFFFFF;
		bh  = b >> 20;
		bl  = b & 64'hFFFFF;
		mid = ah * bl + al * bh + ((al * bl) >> 20);
		return ah * bh + (mid >> 20);
	endfunction

	function automatic logic [63:0] div_small(input logic [63:0] t, input logic [4:0] k);
		logic [63:0] q;
		case (k)
			5'd2:  q = t / 2;   5'd3:  q = t / 3;   5'd4:  q = t / 4;   5'd5:  q = t / 5;
			5'd6:  q = t / 6;   5'd7:  q = t / 7;   5'd8:  q = t / 8;   5'd9:  q = t / 9;
			5'd10: q = t / 10;  5'd11: q = t / 11;  5'd12: q = t / 12;  5'd13: q = t / 13;
			5'd14: q = t / 14;  5'd15: q = t / 15;  5'd16: q = t / 16;  5'd17: q = t / 17;
			5'd18: q = t / 18;  5'd19: q = t / 19;  5'd20: q = t / 20;  5'd21: q = t / 21;
			5'd22: q = t / 22;  5'd23: q = t / 23;  5'd24: q = t / 24;  5'd25: q = t / 25;
			5'd26: q = t / 26;  5'd27: q = t / 27;  5'd28: q = t / 28;  5'd29: q = t / 29;
			5'd30: q = t / 30;
			default: q = t;
		endcase
		return q;
	endfunction

	// exp(-16*i/depth) in q0.16: taylor series for exp(-i/depth), squared four times
	function automatic logic [15:0] gauss_entry(input int unsigned i);
		longint      acc;
		logic [63:0] term, v, r;
		acc  = longint'(Q40_ONE);
		term = Q40_ONE;
		for (int unsigned k = 1; k <= 30; k++) begin
			term = div_small((term * 64'(i)) / EXP_TABLE_DEPTH, 5'(k));
			if (k[0])
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		if (acc < 0)
			acc = 0;
		v = 64'(acc);
		if (v > Q40_ONE)
			v = Q40_ONE;
		for (int unsigned k = 0; k < 4; k++)
			v = mul_q40(v, v);
		r = (v + (64'd1 << 23)) >> 24;
		if (r > 64'd65535)
			r = 64'd65535;
		return r[15:0];
	endfunction

	logic [15:0] gauss_rom [EXP_TABLE_DEPTH];

	for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++) begin : g_rom
		localparam logic [15:0] ENTRY = gauss_entry(gi);
		assign gauss_rom[gi] = ENTRY;
	end

	// pipeline

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [15:0] w_s1, w_s2, w_s3, w_s4, w_s5;
	logic last_s1, last_s2, last_s3, last_s4, last_s5;
	logic [15:0] d_s1;
	logic [31:0] dd_s2;
	logic [47:0] x_s3;
	logic hit_s4;
	logic [IW-1:0] idx_s4;
	logic [15:0] g_s5;
	wcs_item_t item_s6;

	logic [15:0] sigma_eff;
	logic [SW-1:0] scaled;
	logic keep;

	// a held result in the last stage stalls the whole pipe
	assign en = !(v_s6 && !item_ready);
	assign full = !en;

	assign sigma_eff = (inv_sigma_sq == 16'd0) ? 16'd1 : inv_sigma_sq;
	assign scaled = SW'(x_s3[WCS_EXP_SPAN_BITS-1:0]) * SW'(EXP_TABLE_DEPTH);
	assign keep = w_s5 > WCS_NOISE_FLOOR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1    <= rail_weight;
			d_s1    <= distance_m;
			last_s1 <= last_pixel;

			w_s2    <= w_s1;
			last_s2 <= last_s1;
			dd_s2   <= 32'(d_s1) * 32'(d_s1);

			w_s3    <= w_s2;
			last_s3 <= last_s2;
			x_s3    <= 48'(dd_s2) * 48'(sigma_eff);

			w_s4    <= w_s3;
			last_s4 <= last_s3;
			hit_s4  <= x_s3[47:WCS_EXP_SPAN_BITS] == '0;
			idx_s4  <= scaled[WCS_EXP_SPAN_BITS +: IW];

			w_s5    <= w_s4;
			last_s5 <= last_s4;
			g_s5    <= hit_s4 ? gauss_rom[idx_s4] : 16'd0;

			item_s6.product <= keep ? 32'(w_s5) * 32'(g_s5) : 32'd0;
			item_s6.weight  <= keep ? w_s5 : 16'd0;
			item_s6.last    <= last_s5;
		end
	end

	assign item = item_s6;
	assign item_valid = v_s6;

endmodule

>>> rtl/wcs_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcs_fifo: short item queue
// Decouples the lookup pipeline from the accumulator and divider.
// ----------------------------------------------------------------------------
module wcs_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  wcs_pkg::wcs_item_t wr_data,
	output logic               full,
	input  logic               rd_en,
	output wcs_pkg::wcs_item_t rd_data,
	output logic               empty
);
	import wcs_pkg::*;

	localparam int unsigned PW = $clog2(WCS_QUEUE_DEPTH);

	wcs_item_t mem_q [WCS_QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0] count_q;
	logic do_wr, do_rd;

	assign full  = count_q == (PW+1)'(WCS_QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PW'(WCS_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PW'(WCS_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

>>> rtl/wcs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcs_back: accumulator, frame divider and result register
// Sums weight*gaussian and weight per frame, divides at frame end with a
// radix-2 restoring divider and holds the result for the reader.
// ----------------------------------------------------------------------------
module wcs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  wcs_pkg::wcs_item_t item,
	input  logic               item_valid,
	output logic               item_take,
	input  logic [31:0]        min_weight_sum,
	output logic               empty,
	input  logic               pop,
	output logic [15:0]        match_score,
	output logic               too_little_weight
);
	import wcs_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [3:0] cnt_q;
	logic [47:0] score_sum_q;
	logic [31:0] weight_total_q;
	logic res_valid_q;

	logic [47:0] num_q;
	logic [31:0] den_q;
	logic [31:0] rem_q;
	logic [15:0] low_q;
	logic [15:0] quo_q;
	logic flag_q;
	logic [15:0] score_out_q;
	logic flag_out_q;

	logic [48:0] score_add;
	logic [32:0] weight_add;
	logic [47:0] score_sat;
	logic [31:0] weight_sat;
	logic [32:0] trial;
	logic trial_ge;
	logic load;

	// a frame end waits until the divider is free
	assign item_take = item_valid && (!item.last || state_q == ST_IDLE);

	assign score_add  = 49'(score_sum_q) + 49'(item.product);
	assign weight_add = 33'(weight_total_q) + 33'(item.weight);
	assign score_sat  = score_add[48] ? '1 : score_add[47:0];
	assign weight_sat = weight_add[32] ? '1 : weight_add[31:0];

	assign trial    = {rem_q, low_q[15]};
	assign trial_ge = trial >= {1'b0, den_q};

	assign load = state_q == ST_DONE && (!res_valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			score_sum_q    <= '0;
			weight_total_q <= '0;
			res_valid_q    <= 1'b0;
		end else begin
			if (item_take) begin
				if (item.last) begin
					score_sum_q    <= '0;
					weight_total_q <= '0;
				end else begin
					score_sum_q    <= score_sat;
					weight_total_q <= weight_sat;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (item_take && item.last)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (den_q < min_weight_sum || den_q == '0 || num_q >= {den_q, 16'd0})
						state_q <= ST_DONE;
					else begin
						state_q <= ST_DIV;
						cnt_q   <= 4'd15;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			if (load)
				res_valid_q <= 1'b1;
			else if (pop)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take && item.last) begin
			num_q <= score_sat;
			den_q <= weight_sat;
		end
		if (state_q == ST_CHECK) begin
			rem_q  <= num_q[47:16];
			low_q  <= num_q[15:0];
			flag_q <= 1'b0;
			if (den_q < min_weight_sum) begin
				quo_q  <= 16'd0;
				flag_q <= 1'b1;
			end else if (den_q == '0)
				quo_q <= 16'd0;
			else if (num_q >= {den_q, 16'd0})
				quo_q <= 16'hFFFF;
		end
		if (state_q == ST_DIV) begin
			rem_q <= trial_ge ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			low_q <= {low_q[14:0], 1'b0};
			quo_q <= {quo_q[14:0], trial_ge};
		end
		if (load) begin
			score_out_q <= quo_q;
			flag_out_q  <= flag_q;
		end
	end

	assign empty = !res_valid_q;
	assign match_score = score_out_q;
	assign too_little_weight = flag_out_q;

endmodule

>>> rtl/weighted_chamfer_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_chamfer_score: gaussian weighted chamfer matching score
// Per frame, sum of weight*exp(-d^2/sigma^2) over weight sum, in q0.16.
// ----------------------------------------------------------------------------
// usage
//   pixels go in through push/full: a transfer happens on a clock edge with
//   push high and full low; rail_weight, distance_m and last_pixel travel
//   together. one pixel per cycle is sustained within a frame while full is low.
//   the frame score comes out through empty/pop: while empty is low the
//   oldest score sits on match_score/too_little_weight, a transfer happens on
//   an edge with pop high and empty low. one score per frame, none otherwise.
//   after the transfer of the last pixel, its item passes the six stage lookup
//   pipe, the queue and the divider before empty falls.
//   at each frame end the divider goes busy; only a further frame end waits for
//   it; the four entry queue absorbs part and full is raised for any rest.
//   while a score waits unread, the next frame keeps streaming; only its own
//   frame end waits for the result register to free up.
//   configuration is written through cfg_write/cfg_index/cfg_data while the
//   block is idle; it takes effect immediately, no read-back.
//   reset clears both sums, the pipeline and the queue, and sets
//   inv_sigma_sq to 1.0 and min_weight_sum to zero; empty is high after it.
// ----------------------------------------------------------------------------
module weighted_chamfer_score #(
	parameter int unsigned EXP_TABLE_DEPTH = wcs_pkg::WCS_EXP_TABLE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// pixel channel
	input  logic        push,
	output logic        full,
	input  logic [15:0] rail_weight,
	input  logic [15:0] distance_m,
	input  logic        last_pixel,
	// score channel
	output logic        empty,
	input  logic        pop,
	output logic [15:0] match_score,
	output logic        too_little_weight,
	// configuration
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	import wcs_pkg::*;

	logic [15:0] inv_sigma_sq_q;
	logic [31:0] min_weight_sum_q;

	wcs_item_t front_item;
	logic front_valid;
	wcs_item_t queue_item;
	logic queue_full, queue_empty;
	logic back_take;

	// configuration registers, 1.0 per square metre after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_sigma_sq_q   <= 16'd256;
			min_weight_sum_q <= 32'd0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				WCS_REG_INV_SIGMA_SQ: inv_sigma_sq_q   <= cfg_data[15:0];
				WCS_REG_MIN_WEIGHT:   min_weight_sum_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// front end: square, scale, table lookup, weight product
	wcs_front #(
		.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.rail_weight (rail_weight),
		.distance_m  (distance_m),
		.last_pixel  (last_pixel),
		.inv_sigma_sq(inv_sigma_sq_q),
		.item        (front_item),
		.item_valid  (front_valid),
		.item_ready  (!queue_full)
	);

	// queue between front end and accumulator
	wcs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (front_valid),
		.wr_data(front_item),
		.full   (queue_full),
		.rd_en  (back_take),
		.rd_data(queue_item),
		.empty  (queue_empty)
	);

	// back end: frame sums, divider, result register
	wcs_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.item             (queue_item),
		.item_valid       (!queue_empty),
		.item_take        (back_take),
		.min_weight_sum   (min_weight_sum_q),
		.empty            (empty),
		.pop              (pop),
		.match_score      (match_score),
		.too_little_weight(too_little_weight)
	);

endmodule

>>> rtl/wcs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcs_checker: port level checks of the chamfer score block
// Watches the pixel and score channels and is bound to the top level.
// ----------------------------------------------------------------------------
module wcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [15:0] match_score,
	input logic        too_little_weight
);

	// a waiting score holds until it is transferred
	a_score_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(match_score) && $stable(too_little_weight))
		else $error("score changed while waiting");

	// a frame with too little weight scores zero
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && too_little_weight |-> match_score == 16'd0)
		else $error("flagged frame with non-zero score");

	// nothing waits right after reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> empty)
		else $error("score present after reset");

	// the pixel channel is open right after reset
	a_reset_open: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !full)
		else $error("full raised after reset");

endmodule

bind weighted_chamfer_score wcs_checker u_wcs_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.full             (full),
	.empty            (empty),
	.pop              (pop),
	.match_score      (match_score),
	.too_little_weight(too_little_weight)
);
